// File: src/iurt_pkg.sv
// shared types and constants for the interval union range table
// no dependencies; imported by every other file of the block
package iurt_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_VALUE_BITS  = 50;

    // fixed beat field widths
    localparam int FIELD_W  = 50;
    localparam int STATUS_W = 2;
    localparam int HIT_W    = 20;
    localparam int COVER_W  = 51;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_QUERY  = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_INVERTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN1,
        ST_FIN2,
        ST_DONE
    } t_state;

    // per-entry outcome of the compare unit
    typedef struct packed {
        logic vld;
        logic ovl;
        logic free;
    } t_scan_flags;

endpackage

// File: src/iurt_if.sv
// valid/ready channel interfaces for input and result beats
// depends on iurt_pkg for the field widths
interface iurt_in_if import iurt_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [FIELD_W-1:0] range_low;
    logic [FIELD_W-1:0] range_high;
    logic [FIELD_W-1:0] query_id;

    modport source (output valid, output kind, output range_low, output range_high,
                    output query_id, input ready);
    modport sink   (input valid, input kind, input range_low, input range_high,
                    input query_id, output ready);
endinterface

interface iurt_out_if import iurt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [HIT_W-1:0]    hit_count;
    logic [COVER_W-1:0]  covered_total;

    modport source (output valid, output status, output hit, output hit_count,
                    output covered_total, input ready);
    modport sink   (input valid, input status, input hit, input hit_count,
                    input covered_total, output ready);
endinterface

// File: src/iurt_mem.sv
// interval storage: one write port, one read port with registered data
// depends on iurt_pkg for the parameter defaults
module iurt_mem import iurt_pkg::*; #(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int WIDTH = 2 * DEF_VALUE_BITS + 1,
    parameter int AW    = $clog2(DEF_TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/iurt_scan.sv
// shared compare unit: tests one stored entry against the working range
// depends on iurt_pkg for t_scan_flags
module iurt_scan import iurt_pkg::*; #(
    parameter int VB = DEF_VALUE_BITS,
    parameter int AW = $clog2(DEF_TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [AW-1:0] i_addr,
    input  logic          i_ent_valid,
    input  logic [VB-1:0] i_ent_low,
    input  logic [VB-1:0] i_ent_high,
    input  logic [VB-1:0] i_lo,
    input  logic [VB-1:0] i_hi,
    output t_scan_flags   o_flags,
    output logic [VB:0]   o_span,
    output logic [VB-1:0] o_low,
    output logic [VB-1:0] o_high,
    output logic [AW-1:0] o_addr
);

    logic          ovl;
    logic          r_vld;
    logic          r_ovl;
    logic          r_free;
    logic [VB:0]   r_span;
    logic [VB-1:0] r_low;
    logic [VB-1:0] r_high;
    logic [AW-1:0] r_addr;

    // inclusive overlap, touching intervals do not count
    assign ovl = i_ent_valid && (i_ent_low <= i_hi) && (i_lo <= i_ent_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovl  <= ovl;
        r_free <= !i_ent_valid || ovl;
        r_span <= {1'b0, i_ent_high} - {1'b0, i_ent_low} + (VB+1)'(1);
        r_low  <= i_ent_low;
        r_high <= i_ent_high;
        r_addr <= i_addr;
    end

    assign o_flags = '{vld: r_vld, ovl: r_ovl, free: r_free};
    assign o_span  = r_span;
    assign o_low   = r_low;
    assign o_high  = r_high;
    assign o_addr  = r_addr;

endmodule

// File: src/interval_union_range_table_core.sv
// top level of the interval union range table: sequencer, accumulators, result register
// depends on iurt_pkg, iurt_if, iurt_mem and iurt_scan
//
// Keeps up to TABLE_DEPTH disjoint inclusive intervals, each with a valid bit, in one
// memory read one entry per cycle. Every query and every insert with an ordered range
// walks the whole table through the shared compare unit: an insert merges all
// overlapping entries into one (clearing them as it goes) and writes the union to the
// lowest free slot, a query looks for a hit; an inverted range skips the walk. The
// block takes no new item until the current one has handed over its result. After
// reset the block runs a clearing pass over the valid bits and takes no beat until it
// is done. Each item gives exactly one result beat, held in an output register, so the
// result may wait on the sink while the block is ready for the next item.
module interval_union_range_table_core import iurt_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iurt_in_if.sink    i_in,
    iurt_out_if.source o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 2);
    localparam int WW = 2 * VALUE_BITS + 1;
    localparam int SW = VALUE_BITS + 1;

    // sequencer
    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;

    // item being worked on
    t_kind                 r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_lo, n_lo;
    logic [VALUE_BITS-1:0] r_hi, n_hi;
    logic [VALUE_BITS-1:0] in_lo, in_hi, in_id;

    // scan accumulators
    logic                  r_any_ovl, n_any_ovl;
    logic                  r_free_found, n_free_found;
    logic [AW-1:0]         r_free_addr, n_free_addr;
    logic [VALUE_BITS-1:0] r_new_lo, n_new_lo;
    logic [VALUE_BITS-1:0] r_new_hi, n_new_hi;
    logic [SW-1:0]         r_removed, n_removed;
    logic [SW-1:0]         r_cov_tmp, n_cov_tmp;
    logic [SW-1:0]         r_span_new, n_span_new;

    // running state
    logic [SW-1:0]         r_covered, n_covered;
    logic [HIT_W-1:0]      r_hits, n_hits;
    t_status               r_status, n_status;
    logic                  r_hit, n_hit;

    // read pipe into the compare unit
    logic                  r_s1_vld, n_s1_vld;
    logic [AW-1:0]         r_s1_addr;

    // memory ports
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WW-1:0]         mem_rdata;

    // compare unit outputs
    t_scan_flags           s_flags;
    logic [SW-1:0]         s_span;
    logic [VALUE_BITS-1:0] s_low;
    logic [VALUE_BITS-1:0] s_high;
    logic [AW-1:0]         s_addr;

    // result register
    logic                  out_load;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic                  r_out_hit;
    logic [HIT_W-1:0]      r_out_hits;
    logic [COVER_W-1:0]    r_out_cov;

    // value fields are cut or widened to the table width
    assign in_lo = VALUE_BITS'(i_in.range_low);
    assign in_hi = VALUE_BITS'(i_in.range_high);
    assign in_id = VALUE_BITS'(i_in.query_id);

    iurt_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // word layout: valid, low, high
    iurt_scan #(
        .VB (VALUE_BITS),
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_s1_vld),
        .i_addr      (r_s1_addr),
        .i_ent_valid (mem_rdata[WW-1]),
        .i_ent_low   (mem_rdata[2*VALUE_BITS-1:VALUE_BITS]),
        .i_ent_high  (mem_rdata[VALUE_BITS-1:0]),
        .i_lo        (r_lo),
        .i_hi        (r_hi),
        .o_flags     (s_flags),
        .o_span      (s_span),
        .o_low       (s_low),
        .o_high      (s_high),
        .o_addr      (s_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_cnt     <= '0;
            r_s1_vld  <= 1'b0;
            r_covered <= '0;
            r_hits    <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_s1_vld  <= n_s1_vld;
            r_covered <= n_covered;
            r_hits    <= n_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_any_ovl    <= n_any_ovl;
        r_free_found <= n_free_found;
        r_free_addr  <= n_free_addr;
        r_new_lo     <= n_new_lo;
        r_new_hi     <= n_new_hi;
        r_removed    <= n_removed;
        r_cov_tmp    <= n_cov_tmp;
        r_span_new   <= n_span_new;
        r_status     <= n_status;
        r_hit        <= n_hit;
        r_s1_addr    <= r_cnt[AW-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_kind       = r_kind;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_any_ovl    = r_any_ovl;
        n_free_found = r_free_found;
        n_free_addr  = r_free_addr;
        n_new_lo     = r_new_lo;
        n_new_hi     = r_new_hi;
        n_removed    = r_removed;
        n_cov_tmp    = r_cov_tmp;
        n_span_new   = r_span_new;
        n_covered    = r_covered;
        n_hits       = r_hits;
        n_status     = r_status;
        n_hit        = r_hit;
        n_s1_vld     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_cnt[AW-1:0];
        mem_wdata    = '0;
        mem_raddr    = r_cnt[AW-1:0];
        out_load     = 1'b0;

        unique case (r_state)
            ST_CLR: begin
                // clearing pass, one entry a cycle
                mem_we = 1'b1;
                if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_kind       = t_kind'(i_in.kind);
                    n_cnt        = '0;
                    n_any_ovl    = 1'b0;
                    n_free_found = 1'b0;
                    n_free_addr  = '0;
                    n_removed    = '0;
                    n_hit        = 1'b0;
                    n_status     = STAT_OK;
                    if (t_kind'(i_in.kind) == KIND_QUERY) begin
                        // a query is an overlap test against the point range
                        n_lo     = in_id;
                        n_hi     = in_id;
                        n_new_lo = in_id;
                        n_new_hi = in_id;
                        n_state  = ST_SCAN;
                    end else begin
                        n_lo     = in_lo;
                        n_hi     = in_hi;
                        n_new_lo = in_lo;
                        n_new_hi = in_hi;
                        if (in_lo > in_hi) begin
                            n_status = STAT_INVERTED;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue reads for the first TABLE_DEPTH counts, then drain two stages
                if (r_cnt < CW'(TABLE_DEPTH)) begin
                    n_s1_vld = 1'b1;
                end
                n_cnt = r_cnt + CW'(1);
                if (s_flags.vld) begin
                    if (s_flags.ovl) begin
                        n_any_ovl = 1'b1;
                        if (r_kind == KIND_INSERT) begin
                            if (s_low < r_new_lo) begin
                                n_new_lo = s_low;
                            end
                            if (s_high > r_new_hi) begin
                                n_new_hi = s_high;
                            end
                            n_removed = r_removed + s_span;
                            // retire the merged entry
                            mem_we    = 1'b1;
                            mem_waddr = s_addr;
                            mem_wdata = '0;
                        end
                    end
                    if (s_flags.free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_addr  = s_addr;
                    end
                end
                if (r_cnt == CW'(TABLE_DEPTH + 1)) begin
                    n_state = ST_FIN1;
                end
            end
            ST_FIN1: begin
                if (r_kind == KIND_QUERY) begin
                    n_hit    = r_any_ovl;
                    n_status = STAT_OK;
                    if (r_any_ovl && (r_hits != HIT_MAX)) begin
                        n_hits = r_hits + HIT_W'(1);
                    end
                    n_state = ST_DONE;
                end else if (!r_any_ovl && !r_free_found) begin
                    n_status = STAT_FULL;
                    n_state  = ST_DONE;
                end else begin
                    n_cov_tmp  = r_covered - r_removed;
                    n_span_new = SW'(r_new_hi) - SW'(r_new_lo) + SW'(1);
                    n_state    = ST_FIN2;
                end
            end
            ST_FIN2: begin
                mem_we    = 1'b1;
                mem_waddr = r_free_addr;
                mem_wdata = {1'b1, r_new_lo, r_new_hi};
                n_covered = r_cov_tmp + r_span_new;
                n_status  = STAT_OK;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hand over once the result register is free
                if (!r_out_vld || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_hit    <= r_hit;
            r_out_hits   <= r_hits;
            r_out_cov    <= COVER_W'(r_covered);
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out_status;
    assign o_out.hit           = r_out_hit;
    assign o_out.hit_count     = r_out_hits;
    assign o_out.covered_total = r_out_cov;

`ifndef SYNTH
    // the union is only written where the scan found room
    a_fin2_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN2) |-> r_free_found)
        else $error("union write without a free slot");

    // only inserts retire entries during a scan
    a_scan_clear_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == ST_SCAN)) |-> (r_kind == KIND_INSERT))
        else $error("entry cleared during a query");

    // a hit is only ever reported with ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.hit) |-> (o_out.status == STAT_OK))
        else $error("hit reported with error status");

    // hit count never goes down
    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_hits >= $past(r_hits)))
        else $error("hit count decreased");

    // disjoint intervals cannot cover more than the value space
    a_cov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_covered <= (SW'(1) << VALUE_BITS))
        else $error("covered total out of range");
`endif

endmodule

// File: bench/interval_union_range_table_core_tb.sv
// self-checking bench for interval_union_range_table_core: a clocked driver and monitor
// around the block, with a table predictor that scores every result beat in order
// depends on iurt_pkg, iurt_if and the core under src
module interval_union_range_table_core_tb;
    import iurt_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam logic [FIELD_W-1:0] VAL_MAX = '1;
    // random windows stay this far below the top so offsets never wrap
    localparam logic [FIELD_W-1:0] WINDOW_SPAN = 1 << 20;
    // receiver hold-off, long enough for the result register and the input to back up
    localparam int LONG_HOLD = 3000;
    // an item walk and the clearing pass are both short beside the long hold-off,
    // which dominates, so this leaves a wide margin
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 20;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } t_pace;

    // one input beat
    typedef struct packed {
        t_kind              kind;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] id;
    } t_span_req;

    // one result beat
    typedef struct packed {
        t_status             status;
        logic                hit;
        logic [HIT_W-1:0]    hits;
        logic [COVER_W-1:0]  covered;
    } t_table_resp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iurt_in_if  in_bus ();
    iurt_out_if out_bus ();

    interval_union_range_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow copy of the interval table, running totals and bench bookkeeping
    logic [FIELD_W-1:0] span_lo_tbl [TABLE_DEPTH];
    logic [FIELD_W-1:0] span_hi_tbl [TABLE_DEPTH];
    bit                 span_vld_tbl [TABLE_DEPTH];
    logic [COVER_W-1:0] covered_sum = '0;
    logic [HIT_W-1:0]   hit_tally = '0;

    t_span_req   span_pending [$];     // items not yet offered
    t_table_resp expected_resp_q [$];  // predicted results in acceptance order
    t_span_req   on_bus;               // item currently offered
    t_pace       pace = PACE_FREE;
    int          hold_req_seq = 0;
    int          hold_seen;
    int          hold_left;
    int          idle_cycles;
    int          fail_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // table predictor: applies one accepted item to the shadow table
    // ---------------------------------------------------------------------
    function automatic t_table_resp table_outcome(t_span_req rq);
        t_table_resp        rsp;
        logic [FIELD_W-1:0] u_lo;
        logic [FIELD_W-1:0] u_hi;
        logic [COVER_W-1:0] removed;
        bit                 overlap;
        int                 free_at;
        rsp        = '0;
        rsp.status = STAT_OK;
        if (rq.kind == KIND_QUERY) begin
            // range fields play no part in a query
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (span_vld_tbl[k] && span_lo_tbl[k] <= rq.id && rq.id <= span_hi_tbl[k])
                    rsp.hit = 1'b1;
            end
            // hit counter sticks at its maximum
            if (rsp.hit && hit_tally != HIT_MAX)
                hit_tally = hit_tally + 1'b1;
        end else if (rq.lo > rq.hi) begin
            // inverted range: rejected, table untouched
            rsp.status = STAT_INVERTED;
        end else begin
            // first look: any overlap at all, and any slot free
            overlap = 1'b0;
            free_at = -1;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (span_vld_tbl[k] && span_lo_tbl[k] <= rq.hi && rq.lo <= span_hi_tbl[k])
                    overlap = 1'b1;
                else if (!span_vld_tbl[k] && free_at < 0)
                    free_at = k;
            end
            if (!overlap && free_at < 0) begin
                rsp.status = STAT_FULL;
            end else begin
                // merge pass: swallow every overlapping entry, then take the lowest free
                // slot, which may be one just cleared; touching entries stay apart
                u_lo    = rq.lo;
                u_hi    = rq.hi;
                removed = '0;
                free_at = -1;
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    if (span_vld_tbl[k] && span_lo_tbl[k] <= rq.hi
                            && rq.lo <= span_hi_tbl[k]) begin
                        if (span_lo_tbl[k] < u_lo) u_lo = span_lo_tbl[k];
                        if (span_hi_tbl[k] > u_hi) u_hi = span_hi_tbl[k];
                        removed = removed + {1'b0, span_hi_tbl[k]} - {1'b0, span_lo_tbl[k]}
                                  + 1'b1;
                        span_vld_tbl[k] = 1'b0;
                    end
                    if (!span_vld_tbl[k] && free_at < 0)
                        free_at = k;
                end
                if (free_at < 0) begin
                    rsp.status = STAT_FULL;
                end else begin
                    span_lo_tbl[free_at]  = u_lo;
                    span_hi_tbl[free_at]  = u_hi;
                    span_vld_tbl[free_at] = 1'b1;
                    covered_sum = covered_sum - removed + ({1'b0, u_hi} - {1'b0, u_lo} + 1'b1);
                end
            end
        end
        rsp.hits    = hit_tally;
        rsp.covered = covered_sum;
        return rsp;
    endfunction

    function automatic bit sender_naps();
        case (pace)
            PACE_SRC_IDLE: return $urandom_range(0, 99) < 50;
            PACE_BOTH:     return $urandom_range(0, 99) < 16;
            default:       return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // driver: offers pending items, predicts each one as it is accepted
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid      <= 1'b0;
            in_bus.kind       <= 1'b0;
            in_bus.range_low  <= '0;
            in_bus.range_high <= '0;
            in_bus.query_id   <= '0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                expected_resp_q.insert(expected_resp_q.size(), table_outcome(on_bus));
            // valid stays up until the beat goes, so decide only when the bus is free
            if (!in_bus.valid || in_bus.ready) begin
                if (span_pending.size() > 0 && !sender_naps()) begin
                    on_bus             = span_pending.pop_front();
                    in_bus.kind       <= on_bus.kind;
                    in_bus.range_low  <= on_bus.lo;
                    in_bus.range_high <= on_bus.hi;
                    in_bus.query_id   <= on_bus.id;
                    in_bus.valid      <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // monitor: scores result beats in order and paces the ready line
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_table_resp want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_resp_q.size() == 0) begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end else begin
                    want = expected_resp_q.pop_front();
                    if (out_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_bus.status);
                        fail_count++;
                    end
                    if (out_bus.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, out_bus.hit);
                        fail_count++;
                    end
                    if (out_bus.hit_count !== want.hits) begin
                        $error("hit_count: expected %0d, got %0d", want.hits,
                               out_bus.hit_count);
                        fail_count++;
                    end
                    if (out_bus.covered_total !== want.covered) begin
                        $error("covered_total: expected %0d, got %0d", want.covered,
                               out_bus.covered_total);
                        fail_count++;
                    end
                end
            end
            // a new hold request starts a long stretch with ready low
            if (hold_seen != hold_req_seq) begin
                hold_seen     <= hold_req_seq;
                hold_left     <= LONG_HOLD;
                out_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                out_bus.ready <= 1'b0;
            end else begin
                case (pace)
                    PACE_SNK_STALL: out_bus.ready <= $urandom_range(0, 99) >= 50;
                    PACE_BOTH:      out_bus.ready <= $urandom_range(0, 99) >= 16;
                    default:        out_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] any_value();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] pick_window();
        logic [FIELD_W-1:0] w;
        w = any_value();
        if (w > VAL_MAX - WINDOW_SPAN)
            w = w - WINDOW_SPAN;
        return w;
    endfunction

    // the field an item ignores still gets random bits
    function automatic void push_insert(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
        t_span_req rq;
        rq.kind = KIND_INSERT;
        rq.lo   = lo;
        rq.hi   = hi;
        rq.id   = any_value();
        span_pending.insert(span_pending.size(), rq);
    endfunction

    function automatic void push_query(logic [FIELD_W-1:0] id);
        t_span_req rq;
        rq.kind = KIND_QUERY;
        rq.lo   = any_value();
        rq.hi   = any_value();
        rq.id   = id;
        span_pending.insert(span_pending.size(), rq);
    endfunction

    // mostly inserts and queries inside one window so ranges overlap and queries hit,
    // plus some inverted noise and stray narrow ranges anywhere in the value space
    function automatic void push_cluster(int n, logic [FIELD_W-1:0] base, int spread);
        int                 roll;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                if ($urandom_range(0, 9) == 0)
                    push_query(any_value());
                else
                    push_query(base + $urandom_range(0, spread));
            end else if (roll < 50) begin
                lo = any_value();
                hi = any_value();
                if (lo < hi)
                    push_insert(hi, lo);
                else
                    push_insert(lo, hi);
            end else if (roll < 52) begin
                lo = any_value();
                if (lo > VAL_MAX - 16)
                    lo = VAL_MAX - 16;
                push_insert(lo, lo + $urandom_range(0, 15));
            end else begin
                lo = base + $urandom_range(0, spread);
                if ($urandom_range(0, 3) == 0)
                    hi = lo + $urandom_range(0, spread / 8);
                else
                    hi = lo + $urandom_range(0, 8);
                push_insert(lo, hi);
            end
        end
    endfunction

    // disjoint short ranges on a stride of four: fills every slot, then the
    // remaining ones come back as table full
    function automatic void push_fill(logic [FIELD_W-1:0] base, int points);
        for (int k = 0; k < points; k++) begin
            push_insert(base + 4 * k, base + 4 * k + $urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
                push_query(base + $urandom_range(0, 4 * points));
        end
    endfunction

    // sender pause: nothing more offered until every result is back
    task automatic wait_drained();
        while (span_pending.size() != 0 || in_bus.valid || expected_resp_q.size() != 0)
            @(negedge i_clk);
    endtask

    // stimulus runs on the falling edge so it never races the clocked processes
    initial begin : stimulus
        logic [FIELD_W-1:0] win_a;
        logic [FIELD_W-1:0] win_b;
        @(posedge i_rst_n);
        @(negedge i_clk);

        // directed: empty table, value extremes, inverted ranges, touching and
        // overlapping merges
        pace = PACE_FREE;
        push_query('0);
        push_query(VAL_MAX);
        push_insert('0, '0);
        push_insert(VAL_MAX, VAL_MAX);
        push_query('0);
        push_query(VAL_MAX);
        push_query(1);
        push_insert(5, 4);
        push_insert(VAL_MAX, '0);
        push_insert(10, 20);
        push_insert(21, 30);            // touches the one below, stays separate
        push_query(20);
        push_query(21);
        push_insert(5, 10);             // overlaps at one value
        push_insert(1, 100);            // swallows two, touches the point at zero
        push_query(100);
        push_query(101);
        push_insert(VAL_MAX - 10, VAL_MAX - 1);
        push_insert(VAL_MAX - 5, VAL_MAX);
        push_insert(2, 3);              // wholly inside a stored interval
        wait_drained();

        // random, no idling
        win_a = pick_window();
        push_cluster(350, win_a, 4000);
        wait_drained();

        // fill the table to overflow while the sender idles
        pace = PACE_SRC_IDLE;
        win_b = pick_window();
        push_fill(win_b, 300);
        wait_drained();

        // wide merges on the full table free slots again, receiver stalling
        pace = PACE_SNK_STALL;
        push_cluster(370, win_b, 1200);
        wait_drained();

        pace = PACE_BOTH;
        push_cluster(370, win_a, 4000);
        wait_drained();

        // long receiver hold-off with the sender still offering
        pace = PACE_FREE;
        hold_req_seq = hold_req_seq + 1;
        push_cluster(180, win_b, 1200);
        wait_drained();
        push_cluster(180, win_a, 4000);

        // the whole value space in one interval, then merges into it
        push_insert('0, VAL_MAX);
        push_query(any_value());
        push_insert(3, 7);
        push_insert(VAL_MAX, VAL_MAX - 1);
        push_insert(VAL_MAX, VAL_MAX);
        push_query(VAL_MAX);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
